[src/u8sd_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8sd_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned CntW = 3;

  typedef enum logic [1:0] {
    KIND_VALID   = 2'd0,
    KIND_INVALID = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  // One decoded command: n_inv invalid results, then an optional tail result.
  typedef struct packed {
    logic [CntW-1:0] n_inv;
    logic            has_tail;
    kind_e           tail_kind;
    logic [CpW-1:0]  tail_cp;
  } cmd_t;

endpackage

`default_nettype wire

[src/u8sd_front.sv]
// Front end: tracks the pending sequence and classifies each byte into a command.
`default_nettype none

module u8sd_front import u8sd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  output logic            cmd_valid_o,
  output cmd_t            cmd_o
);

  logic [CpW-1:0]  pv_q, pv_d;
  logic [1:0]      need_q, need_d;
  logic [CntW-1:0] len_q, len_d;

  logic [CpW-1:0]  ext_pv;
  logic [CntW-1:0] ext_len;
  logic [1:0]      ext_need;
  logic            is_cont;
  cmd_t            cmd;

  function automatic logic value_ok(input logic [CpW-1:0] cp, input logic [CntW-1:0] len);
    logic ok;
    ok = 1'b0;
    unique case (len)
      3'd2:    ok = (cp >= CpW'(32'h80));
      3'd3:    ok = (cp >= CpW'(32'h800)) &&
                    ((cp < CpW'(32'hD800)) || (cp > CpW'(32'hDFFF)));
      3'd4:    ok = (cp >= CpW'(32'h10000)) && (cp <= CpW'(32'h10FFFF));
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  assign is_cont  = (data_byte_i[7:6] == 2'b10);
  assign ext_pv   = {pv_q[CpW-7:0], data_byte_i[5:0]};
  assign ext_len  = len_q + CntW'(1);
  assign ext_need = need_q - 2'd1;

  always_comb begin
    pv_d          = pv_q;
    need_d        = need_q;
    len_d         = len_q;
    cmd.n_inv     = '0;
    cmd.has_tail  = 1'b0;
    cmd.tail_kind = KIND_VALID;
    cmd.tail_cp   = '0;
    if ((need_q != 2'd0) && is_cont) begin
      pv_d   = ext_pv;
      len_d  = ext_len;
      need_d = ext_need;
      if (ext_need == 2'd0) begin
        pv_d  = '0;
        len_d = '0;
        if (value_ok(ext_pv, ext_len)) begin
          cmd.has_tail = 1'b1;
          cmd.tail_cp  = ext_pv;
        end else begin
          cmd.n_inv = ext_len;
        end
      end
    end else begin
      // Flush a broken sequence, then treat the byte as fresh.
      if (need_q != 2'd0) begin
        cmd.n_inv = len_q;
        pv_d      = '0;
        need_d    = 2'd0;
        len_d     = '0;
      end
      priority if (data_byte_i == 8'h00) begin
        cmd.has_tail  = 1'b1;
        cmd.tail_kind = KIND_END;
      end else if (data_byte_i[7] == 1'b0) begin
        cmd.has_tail = 1'b1;
        cmd.tail_cp  = {{(CpW-8){1'b0}}, data_byte_i};
      end else if (data_byte_i[7:5] == 3'b110) begin
        pv_d   = {{(CpW-5){1'b0}}, data_byte_i[4:0]};
        need_d = 2'd1;
        len_d  = CntW'(1);
      end else if (data_byte_i[7:4] == 4'b1110) begin
        pv_d   = {{(CpW-4){1'b0}}, data_byte_i[3:0]};
        need_d = 2'd2;
        len_d  = CntW'(1);
      end else if (data_byte_i[7:3] == 5'b11110) begin
        pv_d   = {{(CpW-3){1'b0}}, data_byte_i[2:0]};
        need_d = 2'd3;
        len_d  = CntW'(1);
      end else begin
        cmd.has_tail  = 1'b1;
        cmd.tail_kind = KIND_INVALID;
      end
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept_i && ((cmd.n_inv != '0) || cmd.has_tail);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= '0;
      need_q <= 2'd0;
      len_q  <= '0;
    end else if (accept_i) begin
      pv_q   <= pv_d;
      need_q <= need_d;
      len_q  <= len_d;
    end
  end

endmodule

`default_nettype wire

[src/u8sd_fifo.sv]
// Command queue between the front end and the result expander.
`default_nettype none

module u8sd_fifo import u8sd_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t wdata_i,
  input  wire logic pop_i,
  output cmd_t      rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW2 = $clog2(Depth + 1);

  cmd_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW2-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW2'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW2'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW2'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[src/u8sd_back.sv]
// Back end: expands queued commands into single results behind an output register.
`default_nettype none

module u8sd_back import u8sd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_valid_i,
  input  wire cmd_t            head_i,
  output logic                 head_pop_o,
  input  wire logic            pop,
  output logic                 empty,
  output logic [1:0]           kind_o,
  output logic [CpW-1:0]       code_point_o,
  output logic                 last_o
);

  logic            out_valid_q, out_valid_d;
  kind_e           kind_q, kind_d;
  logic [CpW-1:0]  cp_q, cp_d;
  logic            last_q, last_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            load;

  assign load = !out_valid_q || pop;

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    cp_d        = cp_q;
    last_d      = last_q;
    idx_d       = idx_q;
    head_pop_o  = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        if (idx_q < head_i.n_inv) begin
          kind_d = KIND_INVALID;
          cp_d   = '0;
          last_d = (idx_q == head_i.n_inv - CntW'(1)) && !head_i.has_tail;
        end else begin
          kind_d = head_i.tail_kind;
          cp_d   = head_i.tail_cp;
          last_d = 1'b1;
        end
        // Retire the command on its final result.
        if (last_d) begin
          head_pop_o = 1'b1;
          idx_d      = '0;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    cp_q   <= cp_d;
    last_q <= last_d;
  end

  assign empty        = !out_valid_q;
  assign kind_o       = kind_q;
  assign code_point_o = cp_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

[src/utf8_stream_decoder_top.sv]
// Top level of the validating UTF-8 stream decoder.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   input    | push / full            | data_byte_i[7:0]
//   result   | empty / pop            | kind_o[1:0], code_point_o[20:0], last_o
//
// One byte is taken per cycle while the command queue has room; the front end
// classifies it in the cycle of the transfer. The back end presents a byte's
// results one at a time at the output register, each held until it is popped.
// The queue (CmdDepth commands) absorbs bursts of multi-result bytes.
// Reset clears the pending sequence and empties the queue and the output register.
`default_nettype none

module utf8_stream_decoder_top import u8sd_pkg::*; #(
  parameter int unsigned CmdDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind_o,
  output logic [20:0]      code_point_o,
  output logic             last_o
);

  logic cmd_push, fifo_empty, head_pop;
  cmd_t cmd, head;

  u8sd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (push && !full),
    .data_byte_i (data_byte_i),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd)
  );

  u8sd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd),
    .pop_i   (head_pop),
    .rdata_o (head),
    .full_o  (full),
    .empty_o (fifo_empty)
  );

  u8sd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!fifo_empty),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .pop          (pop),
    .empty        (empty),
    .kind_o       (kind_o),
    .code_point_o (code_point_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

[src/u8sd_checker.sv]
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
`default_nettype none

module u8sd_checker import u8sd_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  kind_o,
  input wire logic [20:0] code_point_o,
  input wire logic        last_o
);

  // Only the three defined kinds appear.
  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (kind_o == KIND_VALID || kind_o == KIND_INVALID || kind_o == KIND_END))
    else $error("undefined result kind");

  // Invalid and end results carry no code point.
  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_VALID) |-> (code_point_o == '0))
    else $error("nonzero code point on a non-valid result");

  // A valid result is a Unicode scalar value.
  a_cp_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_VALID) |->
      (code_point_o <= 21'h10FFFF && (code_point_o < 21'hD800 || code_point_o > 21'hDFFF)))
    else $error("valid result outside scalar range");

  // End of string and valid code points are always the final result of a byte.
  a_tail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_INVALID) |-> last_o)
    else $error("tail result without last");

  // A waiting result holds until transfer.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(code_point_o) && $stable(last_o)))
    else $error("result changed while stalled");

endmodule

bind utf8_stream_decoder_top u8sd_checker u_chk (.*);

`default_nettype wire
